[sv/akf_pkg.sv]
`default_nettype none
package akf_pkg;
   localparam int DataWidth = 32;
   localparam int NoiseWidth = 31;
   localparam int StepWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int MulWidth = 34;
   localparam int ProdWidth = 2 * MulWidth;
   localparam int DivNumWidth = 60;
   localparam int DivDenWidth = 33;

   localparam logic [NoiseWidth-1:0] QaReset = 31'd268435;
   localparam logic [NoiseWidth-1:0] QbReset = 31'd805306;
   localparam logic [NoiseWidth-1:0] RReset = 31'd8053064;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_QA = 2'd0,
      CSR_QB = 2'd1,
      CSR_R = 2'd2,
      CSR_START = 2'd3
   } csr_index_type;

   // rounding shift amounts
   typedef enum logic {
      SHIFT_16 = 1'b0,
      SHIFT_28 = 1'b1
   } shift_type;

   typedef struct packed {
      logic start;
      shift_type shift;
      logic signed [MulWidth-1:0] a;
      logic signed [MulWidth-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic start;
      logic signed [DataWidth:0] num;
      logic [DivDenWidth-1:0] den;
   } div_req_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [MulWidth+1:0] v);
      logic signed [MulWidth+1:0] hi;
      logic signed [MulWidth+1:0] lo;
      begin
         hi = (MulWidth+2)'(2147483647);
         lo = -(MulWidth+2)'(64'sd2147483648);
         if (v > hi) return 32'sh7fffffff;
         else if (v < lo) return 32'sh80000000;
         else return v[DataWidth-1:0];
      end
   endfunction
endpackage
`default_nettype wire

[sv/akf_mul.sv]
`default_nettype none
// signed multiply with round half away from zero and right shift, product registered
module akf_mul (
   input wire logic clock,
   input wire logic reset,
   input wire akf_pkg::mul_req_type req,
   output logic done,
   output logic signed [akf_pkg::MulWidth+1:0] result
);
   localparam int MW = akf_pkg::MulWidth;
   localparam int PW = akf_pkg::ProdWidth;

   logic [PW-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   akf_pkg::shift_type shift_ff, shift_in;
   logic busy_ff, busy_in;
   logic [MW-1:0] mag_a, mag_b;
   logic [PW-1:0] rounded;
   logic [PW-1:0] shifted;

   assign mag_a = req.a[MW-1] ? MW'(-req.a) : MW'(req.a);
   assign mag_b = req.b[MW-1] ? MW'(-req.b) : MW'(req.b);
   assign prod_in = PW'(mag_a) * PW'(mag_b);
   assign neg_in = req.a[MW-1] ^ req.b[MW-1];
   assign shift_in = req.shift;
   assign busy_in = req.start;

   always_comb begin
      case (shift_ff)
         akf_pkg::SHIFT_16: begin
            rounded = prod_ff + (PW'(1) << 15);
            shifted = rounded >> 16;
         end
         akf_pkg::SHIFT_28: begin
            rounded = prod_ff + (PW'(1) << 27);
            shifted = rounded >> 28;
         end
         default: begin
            rounded = prod_ff;
            shifted = prod_ff;
         end
      endcase
   end

   // magnitudes stay under 2^35 after the shift in every use
   assign result = neg_ff ? -$signed(shifted[MW+1:0]) : $signed(shifted[MW+1:0]);
   assign done = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      shift_ff <= shift_in;
   end
endmodule
`default_nettype wire

[sv/akf_div.sv]
`default_nettype none
// restoring divider, one quotient bit a cycle, rounded gain num*2^28/den saturated
module akf_div (
   input wire logic clock,
   input wire logic reset,
   input wire akf_pkg::div_req_type req,
   output logic done,
   output logic signed [akf_pkg::DataWidth-1:0] result
);
   localparam int NW = akf_pkg::DivNumWidth;
   localparam int DW = akf_pkg::DivDenWidth;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [CW-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DW:0] trial;
   logic [DW:0] shifted_rem;
   logic [NW:0] q_round;
   logic [NW:0] q_sat;
   logic [DW:0] twice_rem;
   logic [akf_pkg::DataWidth:0] num_mag;

   assign num_mag = req.num[akf_pkg::DataWidth] ? -req.num : req.num;
   assign shifted_rem = {rem_ff[DW-1:0], quo_ff[NW-1]};
   assign trial = shifted_rem - {1'b0, den_ff};
   // round half up: remainder*2 >= den (equal to (n + d/2)/d)
   assign twice_rem = {rem_ff[DW-1:0], 1'b0};
   assign q_round = {1'b0, quo_ff} + ((twice_rem >= {1'b0, den_ff}) ? (NW+1)'(1) : '0);
   assign q_sat = (q_round > (NW+1)'(64'h80000000)) ? (NW+1)'(64'h80000000) : q_round;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = NW'(num_mag) << 28;
         rem_in = '0;
         den_in = req.den;
         neg_in = req.num[akf_pkg::DataWidth];
         count_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DW]) begin
            rem_in = shifted_rem;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (neg_ff) result = akf_pkg::sat32(-(akf_pkg::MulWidth+2)'(q_sat[akf_pkg::DataWidth:0]));
      else result = akf_pkg::sat32((akf_pkg::MulWidth+2)'(q_sat[akf_pkg::DataWidth:0]));
   end
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

[sv/angle_kalman_filter_core.sv]
`default_nettype none
// Two-state angle Kalman filter (angle and gyro bias) in fixed point. Each item makes ten
// passes through one shared rounding multiplier and two gain divisions on a bit-serial
// restoring divider, then loads the result register; a new item is accepted only once the
// previous one has finished these steps. When the innovation variance is not positive both
// divisions are skipped. A new item may be accepted while the previous result waits, and
// the last step holds until that result has been taken. Writing the CSR_START register also
// loads the angle estimate.
module angle_kalman_filter_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic signed [31:0] req_measured_angle,
   input wire logic signed [31:0] req_measured_rate,
   input wire logic [15:0] req_time_step,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [31:0] rsp_filtered_angle,
   output logic signed [31:0] rsp_estimated_bias,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [1:0] csr_index,
   input wire logic [31:0] csr_data
);
   localparam int MW = akf_pkg::MulWidth;
   localparam int EW = MW + 2;

   typedef enum logic [4:0] {
      S_IDLE, S_M_ANG, S_M_T, S_M_C00, S_M_C11, S_DIV0, S_DIV1,
      S_M_A, S_M_B, S_M_P00, S_M_P01, S_M_P10, S_M_P11, S_OUT
   } state_type;

   state_type state_ff;
   logic wait_ff;
   logic [30:0] qa_ff, qb_ff, r_ff;
   logic signed [31:0] angle_ff, bias_ff, c00_ff, c01_ff, c10_ff, c11_ff;
   logic signed [31:0] meas_ff, rate_ff, k0_ff, k1_ff, t_ff, p00_ff, p01_ff;
   logic signed [32:0] y_ff;
   logic [15:0] dt_ff;
   logic signed [31:0] out_a_ff, out_b_ff;
   logic rsp_valid_ff;
   logic [akf_pkg::DivDenWidth-1:0] s_ff;
   logic s_pos_ff;

   akf_pkg::mul_req_type mreq;
   akf_pkg::div_req_type dreq;
   logic mdone, ddone;
   logic signed [EW-1:0] mres;
   logic signed [31:0] dres;
   logic signed [EW-1:0] mres_x;

   assign mres_x = mres;

   akf_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .result(mres));
   akf_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .result(dres));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_angle = out_a_ff;
   assign rsp_estimated_bias = out_b_ff;

   // operand selection for the shared multiplier and the divider, issued on entry to each state
   always_comb begin
      mreq = '0;
      dreq = '0;
      if (!wait_ff) begin
         case (state_ff)
            S_M_ANG: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_16;
               mreq.a = MW'(rate_ff) - MW'(bias_ff);
               mreq.b = MW'({1'b0, dt_ff});
            end
            S_M_T: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_16;
               mreq.a = MW'({1'b0, dt_ff});
               mreq.b = MW'(c11_ff);
            end
            S_M_C00: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_16;
               mreq.a = MW'({1'b0, dt_ff});
               mreq.b = MW'(t_ff) - MW'(c01_ff) - MW'(c10_ff) + MW'({1'b0, qa_ff});
            end
            S_M_C11: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_16;
               mreq.a = MW'({1'b0, qb_ff});
               mreq.b = MW'({1'b0, dt_ff});
            end
            S_DIV0: begin
               dreq.start = s_pos_ff;
               dreq.num = 33'(c00_ff);
               dreq.den = s_ff;
            end
            S_DIV1: begin
               dreq.start = s_pos_ff;
               dreq.num = 33'(c01_ff);
               dreq.den = s_ff;
            end
            S_M_A: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k0_ff);
               mreq.b = MW'(y_ff);
            end
            S_M_B: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k1_ff);
               mreq.b = MW'(y_ff);
            end
            S_M_P00: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k0_ff);
               mreq.b = MW'(p00_ff);
            end
            S_M_P01: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k0_ff);
               mreq.b = MW'(p01_ff);
            end
            S_M_P10: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k1_ff);
               mreq.b = MW'(p00_ff);
            end
            S_M_P11: begin
               mreq.start = 1'b1;
               mreq.shift = akf_pkg::SHIFT_28;
               mreq.a = MW'(k1_ff);
               mreq.b = MW'(p01_ff);
            end
            default: begin
               mreq = '0;
               dreq = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         qa_ff <= akf_pkg::QaReset;
         qb_ff <= akf_pkg::QbReset;
         r_ff <= akf_pkg::RReset;
         angle_ff <= '0;
         bias_ff <= '0;
         c00_ff <= '0;
         c01_ff <= '0;
         c10_ff <= '0;
         c11_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (akf_pkg::csr_index_type'(csr_index))
               akf_pkg::CSR_QA: qa_ff <= csr_data[30:0];
               akf_pkg::CSR_QB: qb_ff <= csr_data[30:0];
               akf_pkg::CSR_R: r_ff <= csr_data[30:0];
               akf_pkg::CSR_START: angle_ff <= $signed(csr_data);
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  meas_ff <= req_measured_angle;
                  rate_ff <= req_measured_rate;
                  dt_ff <= req_time_step;
                  wait_ff <= 1'b0;
                  state_ff <= S_M_ANG;
               end
            end
            S_M_ANG: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  angle_ff <= akf_pkg::sat32(EW'(angle_ff) + mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_M_T;
               end
            end
            S_M_T: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  t_ff <= mres[31:0];
                  wait_ff <= 1'b0;
                  state_ff <= S_M_C00;
               end
            end
            S_M_C00: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c00_ff <= akf_pkg::sat32(EW'(c00_ff) + mres_x);
                  c01_ff <= akf_pkg::sat32(EW'(c01_ff) - EW'(t_ff));
                  c10_ff <= akf_pkg::sat32(EW'(c10_ff) - EW'(t_ff));
                  wait_ff <= 1'b0;
                  state_ff <= S_M_C11;
               end
            end
            S_M_C11: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c11_ff <= akf_pkg::sat32(EW'(c11_ff) + mres_x);
                  s_ff <= akf_pkg::DivDenWidth'(EW'(c00_ff) + $signed(EW'({1'b0, r_ff})));
                  s_pos_ff <= (EW'(c00_ff) + $signed(EW'({1'b0, r_ff}))) > EW'(0);
                  // innovation uses the predicted angle, kept at full width
                  y_ff <= {meas_ff[31], meas_ff} - {angle_ff[31], angle_ff};
                  wait_ff <= 1'b0;
                  state_ff <= S_DIV0;
               end
            end
            S_DIV0: begin
               wait_ff <= 1'b1;
               if (!s_pos_ff) begin
                  k0_ff <= '0;
                  k1_ff <= '0;
                  wait_ff <= 1'b0;
                  state_ff <= S_M_A;
               end else if (ddone) begin
                  k0_ff <= dres;
                  wait_ff <= 1'b0;
                  state_ff <= S_DIV1;
               end
            end
            S_DIV1: begin
               wait_ff <= 1'b1;
               if (ddone) begin
                  k1_ff <= dres;
                  wait_ff <= 1'b0;
                  state_ff <= S_M_A;
               end
            end
            S_M_A: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  angle_ff <= akf_pkg::sat32(EW'(angle_ff) + mres_x);
                  p00_ff <= c00_ff;
                  p01_ff <= c01_ff;
                  wait_ff <= 1'b0;
                  state_ff <= S_M_B;
               end
            end
            S_M_B: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  bias_ff <= akf_pkg::sat32(EW'(bias_ff) + mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_M_P00;
               end
            end
            S_M_P00: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c00_ff <= akf_pkg::sat32(EW'(c00_ff) - mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_M_P01;
               end
            end
            S_M_P01: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c01_ff <= akf_pkg::sat32(EW'(c01_ff) - mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_M_P10;
               end
            end
            S_M_P10: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c10_ff <= akf_pkg::sat32(EW'(c10_ff) - mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_M_P11;
               end
            end
            S_M_P11: begin
               wait_ff <= 1'b1;
               if (mdone) begin
                  c11_ff <= akf_pkg::sat32(EW'(c11_ff) - mres_x);
                  wait_ff <= 1'b0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold until the previous item has left the output register
               if (!rsp_valid_ff) begin
                  out_a_ff <= angle_ff;
                  out_b_ff <= bias_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_M_ANG)) else $error("accept lost");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_valid_ff) |=> rsp_valid) else $error("result lost");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mreq.start && dreq.start)) else $error("two units issued");
endmodule
`default_nettype wire
